// ===== rtl/core/rstpu_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Range sum tree package
// Shared sizes, codes and types of the range sum tree point update unit.
// ----------------------------------------------------------------------------
package rstpu_pkg;

  localparam int MaxElems  = 1024;
  localparam int TreeNodes = 2 * MaxElems;
  localparam int NodeW     = $clog2(TreeNodes);
  localparam int PtrW      = NodeW + 1;
  localparam int IdxW      = 10;
  localparam int CountW    = 11;
  localparam int DataW     = 32;

  localparam logic [CountW-1:0] CountReset = CountW'(1024);
  localparam logic [DataW-1:0]  SumInvalid = '1;

  typedef enum logic {
    OP_WRITE = 1'b0,
    OP_QUERY = 1'b1
  } op_e;

  typedef enum logic {
    STATUS_OK      = 1'b0,
    STATUS_INVALID = 1'b1
  } status_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WR_LEAF,
    ST_WR_UP,
    ST_QUERY,
    ST_EMIT
  } state_e;

endpackage

// ===== rtl/core/rstpu_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Range sum tree channels
// Valid/ready channels for input words, result words and configuration.
// ----------------------------------------------------------------------------
interface rstpu_in_if;
  import rstpu_pkg::*;
  logic                    valid;
  logic                    ready;
  logic                    op;
  logic [IdxW-1:0]         index;
  logic signed [DataW-1:0] value;
  logic [IdxW-1:0]         range_lo;
  logic [IdxW-1:0]         range_hi;

  modport source (output valid, op, index, value, range_lo, range_hi, input ready);
  modport sink (input valid, op, index, value, range_lo, range_hi, output ready);
endinterface

interface rstpu_out_if;
  import rstpu_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [DataW-1:0] sum;
  logic                    status;

  modport source (output valid, sum, status, input ready);
  modport sink (input valid, sum, status, output ready);
endinterface

interface rstpu_cfg_if;
  import rstpu_pkg::*;
  logic              valid;
  logic              ready;
  logic [CountW-1:0] element_count;

  modport source (output valid, element_count, input ready);
  modport sink (input valid, element_count, output ready);
endinterface

// ===== rtl/core/rstpu_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and two read ports, read data registered.
// ----------------------------------------------------------------------------
module rstpu_ram #(
  parameter int Width = 32,
  parameter int Depth = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_a_i,
  output logic [Width-1:0]         rdata_a_o,
  input  logic [$clog2(Depth)-1:0] raddr_b_i,
  output logic [Width-1:0]         rdata_b_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_a_o <= mem_q[raddr_a_i];
    rdata_b_o <= mem_q[raddr_b_i];
  end

endmodule

// ===== rtl/core/range_sum_tree_point_update_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Range sum tree point update unit
// Keeps a tree of partial sums in one RAM and serves point writes and
// inclusive range sum queries, one word at a time.
// ----------------------------------------------------------------------------
// After reset the unit sweeps the tree RAM to zero, one node per cycle, and
// takes no input word until that is done. A write reads its leaf, then writes
// one tree level per cycle on its way to the root, and then hands its result
// to the output register once that register is free. A query reads up to two
// nodes per level through the two RAM read ports. Rejected words go straight
// to the emit state. The output register lets a new word enter while the
// previous result waits.
module range_sum_tree_point_update_unit
  import rstpu_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  rstpu_cfg_if.sink   cfg_i,
  rstpu_in_if.sink    in_i,
  rstpu_out_if.source out_o
);

  state_e            state_q, state_d;
  logic [NodeW-1:0]  clr_cnt_q, clr_cnt_d;
  logic [NodeW-1:0]  node_q, node_d;
  logic [DataW-1:0]  val_q, val_d;
  logic [DataW-1:0]  diff_q, diff_d;
  logic [PtrW-1:0]   l_q, l_d;
  logic [PtrW-1:0]   r_q, r_d;
  logic              hit_a_q, hit_a_d;
  logic              hit_b_q, hit_b_d;
  logic [DataW-1:0]  acc_q, acc_d;
  logic              status_q, status_d;
  logic [CountW-1:0] count_q;
  logic              out_valid_q, out_valid_d;
  logic [DataW-1:0]  out_sum_q, out_sum_d;
  logic              out_status_q, out_status_d;

  logic              ram_we;
  logic [NodeW-1:0]  ram_waddr;
  logic [DataW-1:0]  ram_wdata;
  logic [NodeW-1:0]  ram_ra_addr;
  logic [NodeW-1:0]  ram_rb_addr;
  logic [DataW-1:0]  ram_rd_a;
  logic [DataW-1:0]  ram_rd_b;

  logic [CountW-1:0] active_n;
  logic [NodeW-1:0]  leaf_addr;
  logic [PtrW-1:0]   r_dec;
  logic              act;
  logic              take_l;
  logic              take_r;
  logic              accept;
  logic              out_free;

  rstpu_ram #(
    .Width(DataW),
    .Depth(TreeNodes)
  ) u_tree_ram (
    .clk_i    (clk_i),
    .we_i     (ram_we),
    .waddr_i  (ram_waddr),
    .wdata_i  (ram_wdata),
    .raddr_a_i(ram_ra_addr),
    .rdata_a_o(ram_rd_a),
    .raddr_b_i(ram_rb_addr),
    .rdata_b_o(ram_rd_b)
  );

  assign cfg_i.ready  = 1'b1;
  assign in_i.ready   = (state_q == ST_IDLE);
  assign out_o.valid  = out_valid_q;
  assign out_o.sum    = out_sum_q;
  assign out_o.status = out_status_q;

  assign accept    = in_i.valid && in_i.ready;
  assign out_free  = !out_valid_q || out_o.ready;
  assign active_n  = (count_q > CountW'(MaxElems)) ? CountW'(MaxElems) : count_q;
  assign leaf_addr = NodeW'(MaxElems) + NodeW'(in_i.index);
  assign r_dec     = r_q - PtrW'(1);
  assign act       = (l_q < r_q);
  assign take_l    = act && l_q[0];
  assign take_r    = act && r_q[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
      count_q     <= CountReset;
      hit_a_q     <= 1'b0;
      hit_b_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      out_valid_q <= out_valid_d;
      hit_a_q     <= hit_a_d;
      hit_b_q     <= hit_b_d;
      if (cfg_i.valid && cfg_i.ready) begin
        count_q <= cfg_i.element_count;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    node_q       <= node_d;
    val_q        <= val_d;
    diff_q       <= diff_d;
    l_q          <= l_d;
    r_q          <= r_d;
    acc_q        <= acc_d;
    status_q     <= status_d;
    out_sum_q    <= out_sum_d;
    out_status_q <= out_status_d;
  end

  always_comb begin
    state_d      = state_q;
    clr_cnt_d    = clr_cnt_q;
    node_d       = node_q;
    val_d        = val_q;
    diff_d       = diff_q;
    l_d          = l_q;
    r_d          = r_q;
    hit_a_d      = 1'b0;
    hit_b_d      = 1'b0;
    acc_d        = acc_q;
    status_d     = status_q;
    out_valid_d  = out_valid_q && !out_o.ready;
    out_sum_d    = out_sum_q;
    out_status_d = out_status_q;
    ram_we       = 1'b0;
    ram_waddr    = node_q;
    ram_wdata    = val_q;
    ram_ra_addr  = node_q >> 1;
    ram_rb_addr  = r_dec[NodeW-1:0];

    case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt_q;
        ram_wdata = '0;
        clr_cnt_d = clr_cnt_q + NodeW'(1);
        if (clr_cnt_q == NodeW'(TreeNodes - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        ram_ra_addr = leaf_addr;
        if (accept) begin
          if (in_i.op == OP_WRITE) begin
            node_d = leaf_addr;
            val_d  = in_i.value;
            if (CountW'(in_i.index) >= active_n) begin
              acc_d    = '0;
              status_d = STATUS_INVALID;
              state_d  = ST_EMIT;
            end else begin
              state_d = ST_WR_LEAF;
            end
          end else begin
            l_d   = PtrW'(in_i.range_lo) + PtrW'(MaxElems);
            r_d   = PtrW'(in_i.range_hi) + PtrW'(MaxElems) + PtrW'(1);
            acc_d = '0;
            if (in_i.range_lo > in_i.range_hi || CountW'(in_i.range_hi) >= active_n) begin
              acc_d    = SumInvalid;
              status_d = STATUS_INVALID;
              state_d  = ST_EMIT;
            end else begin
              status_d = STATUS_OK;
              state_d  = ST_QUERY;
            end
          end
        end
      end
      ST_WR_LEAF: begin
        ram_we    = 1'b1;
        ram_wdata = val_q;
        diff_d    = val_q - ram_rd_a;
        node_d    = node_q >> 1;
        state_d   = ST_WR_UP;
      end
      ST_WR_UP: begin
        ram_we    = 1'b1;
        ram_wdata = ram_rd_a + diff_q;
        node_d    = node_q >> 1;
        if (node_q == NodeW'(1)) begin
          acc_d    = '0;
          status_d = STATUS_OK;
          state_d  = ST_EMIT;
        end
      end
      ST_QUERY: begin
        ram_ra_addr = l_q[NodeW-1:0];
        ram_rb_addr = r_dec[NodeW-1:0];
        acc_d = acc_q + (hit_a_q ? ram_rd_a : '0) + (hit_b_q ? ram_rd_b : '0);
        hit_a_d = take_l;
        hit_b_d = take_r;
        l_d = (l_q + PtrW'(take_l)) >> 1;
        r_d = r_q >> 1;
        if (!act) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_sum_d    = acc_q;
          out_status_d = status_q;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  a_root_then_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WR_UP && node_q == NodeW'(1)) |=> (state_q == ST_EMIT))
    else $error("Write did not finish after updating the root.");

  a_no_node_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ram_we && state_q != ST_CLEAR) |-> (ram_waddr != '0))
    else $error("Tree update wrote the unused node.");

  a_query_ports_apart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_QUERY && take_l && take_r) |-> (ram_ra_addr != ram_rb_addr))
    else $error("Query read the same node on both ports.");

  a_emit_loads_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && out_free) |=> (out_valid_q && state_q == ST_IDLE))
    else $error("Result was not moved to the output register.");

endmodule
